FILE: hdl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge of aclk, off while in reset
`define TODC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition that must never be seen on a rising edge of aclk outside reset
`define TODC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

FILE: hdl/todc_pkg.sv
// types, constants and digit helpers for the time-of-day counter
package todc_pkg;

    // operation codes on the input tuser
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_UP   = 2'd1;
    localparam logic [1:0] FUNC_DOWN = 2'd2;

    // widths of the stream payloads
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 88;
    localparam int unsigned TEXT_W    = 64;

    // wrap limits of the counter fields
    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [5:0] MIN_MAX   = 6'd59;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [4:0] HALF_DAY  = 5'd12;

    // acceptance limits for a load
    localparam logic [7:0] LOAD_HOUR_LIMIT  = 8'd24;
    localparam logic [7:0] LOAD_MINSEC_LIMIT = 8'd60;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_COLON = 8'h3a;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    // two ascii digits of a value below 64, tens character in the upper byte
    function automatic logic [15:0] ascii_pair(input logic [5:0] v);
        logic [2:0] tens;
        logic [5:0] ones;
        if (v >= 6'd60) begin
            tens = 3'd6;
        end else if (v >= 6'd50) begin
            tens = 3'd5;
        end else if (v >= 6'd40) begin
            tens = 3'd4;
        end else if (v >= 6'd30) begin
            tens = 3'd3;
        end else if (v >= 6'd20) begin
            tens = 3'd2;
        end else if (v >= 6'd10) begin
            tens = 3'd1;
        end else begin
            tens = 3'd0;
        end
        // tens * 10 as tens * 8 + tens * 2
        ones = v - ({3'b000, tens} << 3) - ({3'b000, tens} << 1);
        return {ASCII_ZERO + {5'b00000, tens}, ASCII_ZERO + {4'b0000, ones[3:0]}};
    endfunction

    // full HH:MM:SS text, first character in the top byte
    function automatic logic [63:0] tod_text(input tod_t t);
        return {ascii_pair({1'b0, t.hour}), ASCII_COLON,
                ascii_pair(t.minute), ASCII_COLON,
                ascii_pair(t.second)};
    endfunction

endpackage

FILE: hdl/time_of_day_up_down_counter_top.sv
// top level of the time-of-day up/down counter
// Keeps hours, minutes and seconds and reports them after every input beat,
// together with the eight ascii characters HH:MM:SS. Each input beat loads
// the time (each field only if in range, hours below 24 in either mode),
// steps it forward one second or steps it back one second; the spare
// operation code leaves the time as it is and still reports it. One
// result beat comes out for every input beat: an accepted beat waits in the
// input register, then moves into the result register, where the time
// counters and the text are written together. A new beat is taken every
// cycle while m_tready is high, and one more beat is held in the input
// register while a result waits. The mode bit on the cfg channel picks the
// hour wrap (0: 0..23, 1: 1..12) and takes effect on the next step;
// cfg_ready is always high.
`include "assert_macros.svh"

module time_of_day_up_down_counter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // load_hour[7:0], load_minute[15:8], load_second[23:16]
    input  logic [todc_pkg::S_TDATA_W-1:0]    s_tdata,
    // func[1:0]
    input  logic [todc_pkg::S_TUSER_W-1:0]    s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hour_now[4:0], minute_now[10:5], second_now[16:11],
    // display_text[80:17], zero fill [87:81]
    output logic [todc_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration: twelve_hour_mode in bit 0
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data
);
    import todc_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [1:0] in_func_reg;
    logic [7:0] in_hour_reg;
    logic [7:0] in_minute_reg;
    logic [7:0] in_second_reg;

    // time state doubles as the result register, text alongside it
    tod_t              tod_reg;
    tod_t              tod_next;
    logic [TEXT_W-1:0] text_reg;
    logic              out_valid_reg;

    logic mode_reg;   // 1: twelve-hour wrap
    logic advance;    // input register moves into the result register
    logic [4:0] hour_inc;

    // result register free, or being emptied this cycle
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign hour_inc = tod_reg.hour + 5'd1;

    // one step of the counter
    always_comb begin
        tod_next = tod_reg;
        unique case (in_func_reg)
            FUNC_LOAD: begin
                // each field loaded on its own, out-of-range fields kept
                if (in_hour_reg < LOAD_HOUR_LIMIT) begin
                    tod_next.hour = in_hour_reg[4:0];
                end
                if (in_minute_reg < LOAD_MINSEC_LIMIT) begin
                    tod_next.minute = in_minute_reg[5:0];
                end
                if (in_second_reg < LOAD_MINSEC_LIMIT) begin
                    tod_next.second = in_second_reg[5:0];
                end
            end
            FUNC_UP: begin
                if (tod_reg.second < SEC_MAX) begin
                    tod_next.second = tod_reg.second + 6'd1;
                end else begin
                    tod_next.second = 6'd0;
                    if (tod_reg.minute < MIN_MAX) begin
                        tod_next.minute = tod_reg.minute + 6'd1;
                    end else begin
                        tod_next.minute = 6'd0;
                        // hour carry, wrap depends on mode
                        if (mode_reg) begin
                            tod_next.hour = (hour_inc > HALF_DAY) ? 5'd1 : hour_inc;
                        end else begin
                            tod_next.hour = (hour_inc > HOUR_MAX) ? 5'd0 : hour_inc;
                        end
                    end
                end
            end
            FUNC_DOWN: begin
                if (tod_reg.second != 6'd0) begin
                    tod_next.second = tod_reg.second - 6'd1;
                end else begin
                    tod_next.second = SEC_MAX;
                    if (tod_reg.minute != 6'd0) begin
                        tod_next.minute = tod_reg.minute - 6'd1;
                    end else begin
                        tod_next.minute = MIN_MAX;
                        // hour borrow, wrap depends on mode
                        if (mode_reg) begin
                            tod_next.hour = (tod_reg.hour <= 5'd1) ? HALF_DAY
                                                                   : tod_reg.hour - 5'd1;
                        end else begin
                            tod_next.hour = (tod_reg.hour == 5'd0) ? HOUR_MAX
                                                                   : tod_reg.hour - 5'd1;
                        end
                    end
                end
            end
            default: begin
                // spare code: time unchanged
                tod_next = tod_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
            tod_reg       <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                tod_reg       <= tod_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg   <= s_tuser;
            in_hour_reg   <= s_tdata[7:0];
            in_minute_reg <= s_tdata[15:8];
            in_second_reg <= s_tdata[23:16];
        end
        if (advance) begin
            text_reg <= tod_text(tod_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, text_reg, tod_reg.second, tod_reg.minute, tod_reg.hour};

    // minutes and seconds never leave their range
    `TODC_ASSERT_NEVER(a_min_sec_range,
        (tod_reg.minute > MIN_MAX) || (tod_reg.second > SEC_MAX),
        "minute or second counter out of range")
    // hours never leave the 24-hour range, whatever the mode
    `TODC_ASSERT_NEVER(a_hour_range, tod_reg.hour > HOUR_MAX,
        "hour counter out of range")
    // a held input beat means the result side is stalled
    `TODC_ASSERT_IMPL(a_stall_cause, in_valid_reg && !advance,
        out_valid_reg && !m_tready, "input register held without output stall")
    // the time only changes when a new result beat is loaded
    `TODC_ASSERT_IMPL(a_time_with_result, !$past(advance) && $past(aresetn),
        $stable(tod_reg), "time changed without a result beat")

endmodule

FILE: verif/tb.sv
// testbench for the time-of-day up/down counter: directed and random beats against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // spare operation code, not named in the package
    localparam logic [1:0] FUNC_HOLD = 2'd3;

    // run length and watchdog
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_BEATS     = 136;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 200;
    localparam int SETTLE_CYCLES   = 6;

    // one predicted result beat
    typedef struct {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [63:0] text;
    } tod_result_t;

    // predicts the clock from accepted input beats and checks result beats in order
    class tod_scoreboard;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        bit          twelve_hour;
        tod_result_t time_q[$];
        int          errors;
        int          checked;
        int          hour_rolls;

        function new();
            hour = '0;
            minute = '0;
            second = '0;
            twelve_hour = 1'b0;
            errors = 0;
            checked = 0;
            hour_rolls = 0;
        endfunction

        function void set_mode(bit mode);
            twelve_hour = mode;
        endfunction

        function int pending();
            return time_q.size();
        endfunction

        function logic [15:0] digit_pair(logic [5:0] v);
            return {todc_pkg::ASCII_ZERO + 8'(v / 10), todc_pkg::ASCII_ZERO + 8'(v % 10)};
        endfunction

        function void advance_second();
            logic [5:0] h;
            if (second < 6'd59) begin
                second = second + 6'd1;
                return;
            end
            second = '0;
            if (minute < 6'd59) begin
                minute = minute + 6'd1;
                return;
            end
            minute = '0;
            hour_rolls++;
            h = {1'b0, hour} + 6'd1;
            if (twelve_hour) begin
                if (h > 6'd12) h = 6'd1;
            end else begin
                if (h > 6'd23) h = 6'd0;
            end
            hour = h[4:0];
        endfunction

        function void retreat_second();
            if (second > 6'd0) begin
                second = second - 6'd1;
                return;
            end
            second = 6'd59;
            if (minute > 6'd0) begin
                minute = minute - 6'd1;
                return;
            end
            minute = 6'd59;
            hour_rolls++;
            if (twelve_hour) begin
                hour = (hour <= 5'd1) ? 5'd12 : hour - 5'd1;
            end else begin
                hour = (hour == 5'd0) ? 5'd23 : hour - 5'd1;
            end
        endfunction

        // one accepted input beat: update the time and queue the result it causes
        function void note_input(logic [1:0] func, logic [7:0] lh, logic [7:0] lm,
                                 logic [7:0] ls);
            tod_result_t r;
            case (func)
                todc_pkg::FUNC_LOAD: begin
                    // each field on its own, out-of-range fields keep their value
                    if (lh < 8'd24) hour = lh[4:0];
                    if (lm < 8'd60) minute = lm[5:0];
                    if (ls < 8'd60) second = ls[5:0];
                end
                todc_pkg::FUNC_UP:   advance_second();
                todc_pkg::FUNC_DOWN: retreat_second();
                default: ;
            endcase
            r.hour = hour;
            r.minute = minute;
            r.second = second;
            r.text = {digit_pair({1'b0, hour}), todc_pkg::ASCII_COLON, digit_pair(minute),
                      todc_pkg::ASCII_COLON, digit_pair(second)};
            time_q.push_back(r);
        endfunction

        function void report(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected 'h%0h, got 'h%0h",
                         $time, what, want, got);
        endfunction

        function void check_result(logic [todc_pkg::M_TDATA_W-1:0] beat);
            tod_result_t want;
            if (time_q.size() == 0) begin
                report("unexpected result beat", 64'd0, beat[63:0]);
                return;
            end
            want = time_q.pop_front();
            checked++;
            if (beat[4:0] !== want.hour)    report("hour", 64'(want.hour), 64'(beat[4:0]));
            if (beat[10:5] !== want.minute) report("minute", 64'(want.minute), 64'(beat[10:5]));
            if (beat[16:11] !== want.second)
                report("second", 64'(want.second), 64'(beat[16:11]));
            if (beat[80:17] !== want.text)  report("text", want.text, beat[80:17]);
            if (beat[87:81] !== 7'd0)       report("zero fill", 64'd0, 64'(beat[87:81]));
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    // load_hour[7:0], load_minute[15:8], load_second[23:16]
    logic [todc_pkg::S_TDATA_W-1:0]   s_tdata;
    // func[1:0]
    logic [todc_pkg::S_TUSER_W-1:0]   s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    // hour_now[4:0], minute_now[10:5], second_now[16:11], display_text[80:17], zeros above
    logic [todc_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic                             cfg_data;

    tod_scoreboard clock_sb;
    int            cycles;
    int            beats_sent;
    // chance in percent that a beat is preceded by idle cycles, per side and phase
    int            send_idle_pct;
    int            sink_idle_pct;

    time_of_day_up_down_counter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int idle_gap(int pct);
        return ($urandom_range(99) < pct) ? $urandom_range(14) : 0;
    endfunction

    // one input beat; entered and left just after a falling edge
    task automatic send_beat(input logic [1:0] func, input logic [7:0] lh,
                             input logic [7:0] lm, input logic [7:0] ls);
        int gap;
        gap = idle_gap(send_idle_pct);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {ls, lm, lh};
        // beat moves on the rising edge with tvalid and tready both high
        do @(posedge aclk); while (!s_tready);
        clock_sb.note_input(func, lh, lm, ls);
        beats_sent++;
        @(negedge aclk);
    endtask

    // hold off until every predicted result has come out, then let the pipe settle
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (clock_sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // hour mode write, only while the block is idle
    task automatic write_mode(input bit mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        clock_sb.set_mode(mode);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls on m_tready, every beat checked on acceptance
    task automatic take_results();
        int gap;
        forever begin
            gap = idle_gap(sink_idle_pct);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            clock_sb.check_result(m_tdata);
            @(negedge aclk);
        end
    endtask

    // minute or second value that sits on or near a carry or borrow
    function automatic logic [7:0] pick_minsec();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd58;
            3: return 8'd59;
            default: return 8'($urandom_range(59));
        endcase
    endfunction

    // hour value, leaning on the wrap points of both modes
    function automatic logic [7:0] pick_hour();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd12;
            3: return 8'd23;
            default: return 8'($urandom_range(23));
        endcase
    endfunction

    // short directed run: wraps in both modes, load field filtering, spare code
    task automatic run_directed();
        // 24-hour mode straight after reset
        send_beat(todc_pkg::FUNC_UP,   8'h00, 8'h00, 8'h00);   // 00:00:01
        send_beat(todc_pkg::FUNC_DOWN, 8'hff, 8'hff, 8'hff);   // 00:00:00
        send_beat(todc_pkg::FUNC_DOWN, 8'h00, 8'h00, 8'h00);   // borrow wraps to 23:59:59
        send_beat(todc_pkg::FUNC_UP,   8'h00, 8'h00, 8'h00);   // carry wraps to 00:00:00
        send_beat(todc_pkg::FUNC_LOAD, 8'd23, 8'd59, 8'd59);
        send_beat(FUNC_HOLD,           8'hff, 8'hff, 8'hff);   // spare code keeps the time
        send_beat(todc_pkg::FUNC_LOAD, 8'd24, 8'd60, 8'd60);   // all just out of range
        send_beat(todc_pkg::FUNC_LOAD, 8'hff, 8'hff, 8'hff);   // all fully out of range
        send_beat(todc_pkg::FUNC_LOAD, 8'd99, 8'd0, 8'd200);   // only the minute written
        send_beat(todc_pkg::FUNC_LOAD, 8'd10, 8'd59, 8'd59);
        send_beat(todc_pkg::FUNC_UP,   8'h00, 8'h00, 8'h00);   // 11:00:00
        send_beat(todc_pkg::FUNC_DOWN, 8'h00, 8'h00, 8'h00);   // 10:59:59
        send_beat(todc_pkg::FUNC_LOAD, 8'd9, 8'd5, 8'd9);
        wait_for_idle();
        // 12-hour mode
        write_mode(1'b1);
        send_beat(todc_pkg::FUNC_LOAD, 8'd12, 8'd59, 8'd59);
        send_beat(todc_pkg::FUNC_UP,   8'h00, 8'h00, 8'h00);   // 12 rolls to 1
        send_beat(todc_pkg::FUNC_DOWN, 8'h00, 8'h00, 8'h00);   // 1 rolls back to 12
        send_beat(todc_pkg::FUNC_LOAD, 8'd0, 8'd59, 8'd59);
        send_beat(todc_pkg::FUNC_UP,   8'h00, 8'h00, 8'h00);   // hour 0 advances to 1
        send_beat(todc_pkg::FUNC_LOAD, 8'd0, 8'd0, 8'd0);
        send_beat(todc_pkg::FUNC_DOWN, 8'h00, 8'h00, 8'h00);   // hour 0 goes back to 12
        send_beat(todc_pkg::FUNC_LOAD, 8'd23, 8'd59, 8'd59);   // above 12 still loads
        send_beat(todc_pkg::FUNC_UP,   8'h00, 8'h00, 8'h00);   // and jumps to 1
        send_beat(todc_pkg::FUNC_LOAD, 8'd23, 8'd0, 8'd0);
        send_beat(todc_pkg::FUNC_DOWN, 8'h00, 8'h00, 8'h00);   // counts down to 22 as usual
        wait_for_idle();
    endtask

    // mostly a load near a wrap followed by a run of steps, the rest raw noise
    task automatic run_random_phase(input int n_beats);
        int          sent;
        int          run_len;
        bit          go_up;
        logic [1:0]  func;
        sent = 0;
        while (sent < n_beats) begin
            if ($urandom_range(99) < 70) begin
                send_beat(todc_pkg::FUNC_LOAD, pick_hour(), pick_minsec(), pick_minsec());
                sent++;
                run_len = $urandom_range(8, 1);
                go_up = 1'($urandom_range(1));
                repeat (run_len) begin
                    func = go_up ? todc_pkg::FUNC_UP : todc_pkg::FUNC_DOWN;
                    // now and then a step the other way or the spare code
                    case ($urandom_range(11))
                        0: func = go_up ? todc_pkg::FUNC_DOWN : todc_pkg::FUNC_UP;
                        1: func = FUNC_HOLD;
                        default: ;
                    endcase
                    send_beat(func, 8'($urandom), 8'($urandom), 8'($urandom));
                    sent++;
                end
            end else begin
                send_beat(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        // every input known from time zero, reset held low first
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = todc_pkg::FUNC_LOAD;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        beats_sent    = 0;
        send_idle_pct = 30;
        sink_idle_pct = 30;
        clock_sb      = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        fork
            take_results();
        join_none

        run_directed();

        // random phases: mode alternates irregularly, idling differs per side and phase
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: send_idle_pct = 0;
                1: send_idle_pct = 30;
                2: send_idle_pct = 100;
                default: send_idle_pct = 60;
            endcase
            case ((p + 1) % 4)
                0: sink_idle_pct = 0;
                1: sink_idle_pct = 30;
                2: sink_idle_pct = 100;
                default: sink_idle_pct = 60;
            endcase
            write_mode((p % 3) != 1);
            run_random_phase(PHASE_BEATS);
            // sender pauses until every predicted beat has come back
            wait_for_idle();
        end

        // drain and let the pipe settle for any stray beat
        while (clock_sb.pending() != 0) @(posedge aclk);
        repeat (4 * SETTLE_CYCLES) @(posedge aclk);

        $display("%0d input beats sent, %0d result beats checked, %0d hour carries or borrows",
                 beats_sent, clock_sb.checked, clock_sb.hour_rolls);
        $display("both hour modes, load field filtering, spare code and random stalls exercised");
        if (clock_sb.errors == 0 && clock_sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/todc_pkg.sv
hdl/time_of_day_up_down_counter_top.sv
verif/tb.sv
